[src/bfha_pkg.sv]
package bfha_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int HEAP_SPAN  = (HEAP_BYTES / 8) * 8;
    localparam int NWORDS     = HEAP_SPAN / 4;
    localparam int AW         = $clog2(NWORDS);
    localparam int PW         = 17;
    localparam int END_POS    = HEAP_SPAN - 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FIT   = 3'd2;
    localparam logic [2:0] ST_BAD_OFF  = 3'd3;
    localparam logic [2:0] ST_OUT_HEAP = 3'd4;
    localparam logic [2:0] ST_DBL_FREE = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [PW-1:0] t_pos;

    typedef struct packed {
        logic        operation;
        logic [12:0] request_size;
        logic [11:0] block_offset;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] payload_offset;
    } t_result;

endpackage

[src/best_fit_heap_allocator_core.sv]
// Best-fit allocator over an implicit block list kept in one 1024 x 16 RAM.
// After reset the block formats the heap (busy high).
// An item is taken when start is high and busy low; its result shows on
// o_result for one cycle with o_done and cannot be stalled. Bad sizes and null,
// misaligned or out-of-heap offsets answer in the cycle after the item is taken.
// Otherwise the walk reads each block header from the RAM and evaluates it,
// up to HEAP_BYTES/8 - 1 headers. An allocate then marks the chosen block and
// splits it or updates the next header; a free checks the header, merges with
// free neighbours and writes the new header and footer.
module best_fit_heap_allocator_core
    import bfha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_ARD, S_AEV, S_AEND, S_ASPL1, S_ASPL2, S_ANXR, S_ANXW,
        S_FRD, S_FEV, S_FCHK, S_FHD, S_FPV, S_FNR, S_FNW, S_FW1, S_FW2
    } t_state;

    t_state      r_state;
    logic [AW-1:0] r_clr;
    logic [15:0] r_mem [NWORDS];
    logic [15:0] r_rdata;

    t_pos  r_pos, r_prev, r_h, r_need, r_best, r_bsize, r_start, r_total, r_nx;
    logic  r_found, r_bpa, r_pbits;
    logic  r_done;
    t_result r_res;

    t_pos        mem_addr;
    logic        mem_we;
    logic [15:0] mem_wdata;
    t_pos        rsz;
    t_pos        req;
    t_pos        off;

    assign rsz = t_pos'({r_rdata[15:2], 2'b00});
    assign req = t_pos'(i_item.request_size);
    assign off = t_pos'(i_item.block_offset);

    always_comb begin
        mem_addr  = r_pos;
        mem_we    = 1'b0;
        mem_wdata = 16'd0;
        case (r_state)
            S_CLEAR: begin
                mem_addr = t_pos'({r_clr, 2'b00});
                mem_we   = 1'b1;
                if (r_clr == AW'(1))
                    mem_wdata = 16'(HEAP_SPAN - 8) | 16'd2;
                else if (r_clr == AW'(NWORDS - 2))
                    mem_wdata = 16'(HEAP_SPAN - 8);
                else if (r_clr == AW'(NWORDS - 1))
                    mem_wdata = 16'd1;
            end
            S_AEND: begin
                mem_addr  = r_best;
                mem_we    = r_found;
                mem_wdata = r_need[15:0] | 16'd1 | {14'd0, r_bpa, 1'b0};
            end
            S_ASPL1: begin
                mem_addr  = r_best + r_need;
                mem_we    = 1'b1;
                mem_wdata = 16'(r_bsize - r_need) | 16'd2;
            end
            S_ASPL2: begin
                mem_addr  = r_best + r_bsize - t_pos'(4);
                mem_we    = 1'b1;
                mem_wdata = 16'(r_bsize - r_need);
            end
            S_ANXR: mem_addr = r_best + r_need;
            S_ANXW: begin
                mem_addr  = r_best + r_need;
                mem_we    = 1'b1;
                mem_wdata = r_rdata | 16'd2;
            end
            S_FCHK: mem_addr = r_h;
            S_FHD:  mem_addr = r_prev;
            S_FNR:  mem_addr = r_nx;
            S_FNW: begin
                mem_addr  = r_nx;
                mem_we    = 1'b1;
                mem_wdata = r_rdata & 16'hFFFD;
            end
            S_FW1: begin
                mem_addr  = r_start;
                mem_we    = 1'b1;
                mem_wdata = r_total[15:0] | {14'd0, r_pbits, 1'b0};
            end
            S_FW2: begin
                mem_addr  = r_start + r_total - t_pos'(4);
                mem_we    = 1'b1;
                mem_wdata = r_total[15:0];
            end
            default: mem_addr = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_addr < t_pos'(HEAP_SPAN)) begin
            if (mem_we)
                r_mem[mem_addr[AW+1:2]] <= mem_wdata;
            r_rdata <= r_mem[mem_addr[AW+1:2]];
        end else begin
            r_rdata <= 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NWORDS - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_res.payload_offset <= '0;
                        r_pos   <= t_pos'(4);
                        r_prev  <= '0;
                        r_found <= 1'b0;
                        r_need  <= (req + t_pos'(11)) & ~t_pos'(7);
                        r_h     <= off - t_pos'(4);
                        if (i_item.operation == OP_ALLOC) begin
                            if (req == '0 || req >= t_pos'(HEAP_SPAN - 16)) begin
                                r_res.status <= ST_BAD_SIZE;
                                r_done       <= 1'b1;
                            end else begin
                                r_state <= S_ARD;
                            end
                        end else if (off == '0 || off[2:0] != 3'd0) begin
                            r_res.status <= ST_BAD_OFF;
                            r_done       <= 1'b1;
                        end else if (off - t_pos'(4) >= t_pos'(END_POS)) begin
                            r_res.status <= ST_OUT_HEAP;
                            r_done       <= 1'b1;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end
                end
                S_ARD: r_state <= (r_pos >= t_pos'(END_POS)) ? S_AEND : S_AEV;
                S_AEV: begin
                    if (rsz == '0) begin
                        r_state <= S_AEND;
                    end else begin
                        r_state <= S_ARD;
                        r_pos   <= r_pos + rsz;
                        if (!r_rdata[0]) begin
                            if (rsz == r_need) begin
                                r_best  <= r_pos;
                                r_bsize <= rsz;
                                r_bpa   <= r_rdata[1];
                                r_found <= 1'b1;
                                r_state <= S_AEND;
                            end else if (rsz > r_need && (!r_found || rsz < r_bsize)) begin
                                r_best  <= r_pos;
                                r_bsize <= rsz;
                                r_bpa   <= r_rdata[1];
                                r_found <= 1'b1;
                            end
                        end
                    end
                end
                S_AEND: begin
                    if (!r_found) begin
                        r_res.status <= ST_NO_FIT;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= (r_bsize > r_need) ? S_ASPL1 : S_ANXR;
                    end
                end
                S_ASPL1: r_state <= S_ASPL2;
                S_ANXR:  r_state <= S_ANXW;
                S_ASPL2, S_ANXW: begin
                    r_res.status         <= ST_OK;
                    r_res.payload_offset <= 12'(r_best + t_pos'(4));
                    r_done               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_FRD: begin
                    if (r_pos >= t_pos'(END_POS) || r_pos == r_h)
                        r_state <= S_FCHK;
                    else
                        r_state <= S_FEV;
                end
                S_FEV: begin
                    if (rsz == '0) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_prev  <= r_pos;
                        r_pos   <= r_pos + rsz;
                        r_state <= S_FRD;
                    end
                end
                S_FCHK: begin
                    if (r_pos != r_h) begin
                        r_res.status <= ST_BAD_OFF;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_FHD;
                    end
                end
                S_FHD: begin
                    if (!r_rdata[0]) begin
                        r_res.status <= ST_DBL_FREE;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_start <= r_h;
                        r_total <= rsz;
                        r_pbits <= r_rdata[1];
                        r_nx    <= r_h + rsz;
                        r_state <= (!r_rdata[1] && r_prev != '0) ? S_FPV : S_FNR;
                    end
                end
                S_FPV: begin
                    r_start <= r_prev;
                    r_total <= r_total + rsz;
                    r_pbits <= r_rdata[1];
                    r_state <= S_FNR;
                end
                S_FNR: r_state <= (r_nx <= t_pos'(END_POS)) ? S_FNW : S_FW1;
                S_FNW: begin
                    if (r_nx < t_pos'(END_POS) && !r_rdata[0] && rsz != '0)
                        r_total <= r_total + rsz;
                    r_state <= S_FW1;
                end
                S_FW1: r_state <= S_FW2;
                S_FW2: begin
                    r_res.status <= ST_OK;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done || $past(start && !busy))
        else $error("done held without new item");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_OK |-> o_result.payload_offset == '0)
        else $error("failed item with payload");
    a_accept_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted item dropped");
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

endmodule
